// File: design/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants for the point projection pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int unsigned CoordW = 38;
  localparam int unsigned AccW   = 52;
  localparam int unsigned NumW   = 66;
  localparam int unsigned DenW   = CoordW + 16;
  localparam int unsigned QuoW   = 17;
  localparam int unsigned ShW    = DenW + QuoW;
  localparam int unsigned IntrW  = 26;

  localparam logic [IntrW-1:0] FX_Q16 = 26'd40509549;
  localparam logic [IntrW-1:0] FY_Q16 = 26'd40582074;
  localparam logic [IntrW-1:0] CX_Q16 = 26'd21668823;
  localparam logic [IntrW-1:0] CY_Q16 = 26'd11504626;

  localparam logic [2:0] REG_ROT_ROW0 = 3'd0;
  localparam logic [2:0] REG_ROT_ROW1 = 3'd1;
  localparam logic [2:0] REG_ROT_ROW2 = 3'd2;
  localparam logic [2:0] REG_TRANS_X  = 3'd3;
  localparam logic [2:0] REG_TRANS_Y  = 3'd4;
  localparam logic [2:0] REG_TRANS_Z  = 3'd5;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [15:0] pixel_u;
    logic signed [15:0] pixel_v;
    logic               behind_camera;
  } pixel_t;

  typedef struct packed {
    logic            valid;
    logic            neg;
    logic            ovf;
    logic            behind;
    logic [NumW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } div_stage_t;

endpackage

// File: design/ppp_xform.sv
// ----------------------------------------------------------------------------
// ppp_xform
// Rigid transform c = R*p + t in three stages: products, sum, truncation.
// ----------------------------------------------------------------------------
module ppp_xform (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  ppp_pkg::point_t               pt,
  input  logic [47:0]                   rot [3],
  input  logic signed [31:0]            trans [3],
  output logic                          out_vld,
  output logic signed [ppp_pkg::CoordW-1:0] coord [3],
  output logic                          behind
);
  import ppp_pkg::*;

  logic                    vld1, vld2;
  logic signed [47:0]      prod [3][3];
  logic signed [AccW-1:0]  acc [3];
  logic signed [31:0]      p [3];
  logic signed [AccW-1:0]  rnd [3];

  assign p[0] = pt.point_x;
  assign p[1] = pt.point_y;
  assign p[2] = pt.point_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = acc[i] < 0 ? (acc[i] + 52'sd16383) >>> 14 : acc[i] >>> 14;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= $signed(rot[i][16*j +: 16]) * p[j];
        end
        acc[i] <= prod[i][0] + prod[i][1] + prod[i][2]
                + $signed({{6{trans[i][31]}}, trans[i], 14'b0});
        coord[i] <= rnd[i][CoordW-1:0];
      end
      behind <= (rnd[2] <= 0);
    end
  end

endmodule

// File: design/ppp_divstep.sv
// ----------------------------------------------------------------------------
// ppp_divstep
// One registered restoring division step producing one quotient bit.
// ----------------------------------------------------------------------------
module ppp_divstep #(
  parameter int unsigned BIT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  ppp_pkg::div_stage_t d_in,
  output ppp_pkg::div_stage_t d_out
);
  import ppp_pkg::*;

  logic [ShW-1:0] sh;
  logic [ShW-1:0] rem_ext;
  logic           take;

  assign sh      = {{QuoW{1'b0}}, d_in.den} << BIT;
  assign rem_ext = {{(ShW-NumW){1'b0}}, d_in.rem};
  assign take    = rem_ext >= sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_in.valid;
    end
    if (en) begin
      d_out.neg    <= d_in.neg;
      d_out.ovf    <= d_in.ovf;
      d_out.behind <= d_in.behind;
      d_out.den    <= d_in.den;
      d_out.rem    <= take ? d_in.rem - sh[NumW-1:0] : d_in.rem;
      d_out.quo    <= d_in.quo | (QuoW'(take) << BIT);
    end
  end

endmodule

// File: design/ppp_proj.sv
// ----------------------------------------------------------------------------
// ppp_proj
// Pinhole projection of one axis: f*a + c*z over z*2^16, pipelined divide,
// truncation toward zero and 16-bit saturation.
// ----------------------------------------------------------------------------
module ppp_proj (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [ppp_pkg::IntrW-1:0]         f,
  input  logic [ppp_pkg::IntrW-1:0]         c,
  input  logic signed [ppp_pkg::CoordW-1:0] a,
  input  logic signed [ppp_pkg::CoordW-1:0] z,
  input  logic                              behind_in,
  output logic                              out_vld,
  output logic signed [15:0]                pix,
  output logic                              behind
);
  import ppp_pkg::*;

  logic                   vld_a, vld_b;
  logic                   bh_a, bh_b;
  logic signed [NumW-1:0] mf, mc, num;
  logic [DenW-1:0]        den_a, den_b;
  div_stage_t             st [QuoW+1];
  logic [QuoW-1:0]        q;
  logic signed [15:0]     pix_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld_a <= in_vld;
      vld_b <= vld_a;
      out_vld <= st[QuoW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (en) begin
      st[0].valid <= vld_b;
    end
    if (en) begin
      mf    <= $signed({1'b0, f}) * a;
      mc    <= $signed({1'b0, c}) * z;
      den_a <= {z[CoordW-1:0], 16'b0};
      bh_a  <= behind_in;
      num   <= mf + mc;
      den_b <= den_a;
      bh_b  <= bh_a;
      st[0].neg    <= num < 0;
      st[0].rem    <= num < 0 ? -num : num;
      st[0].ovf    <= {{(ShW-NumW){1'b0}}, (num < 0 ? -num : num)} >= {den_b, {QuoW{1'b0}}};
      st[0].behind <= bh_b;
      st[0].den    <= den_b;
      st[0].quo    <= '0;
      pix    <= pix_next;
      behind <= st[QuoW].behind;
    end
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    ppp_divstep #(.BIT(QuoW-1-k)) u_step (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (st[k]),
      .d_out (st[k+1])
    );
  end

  assign q = st[QuoW].quo;

  always_comb begin
    if (st[QuoW].behind) begin
      pix_next = '0;
    end else if (!st[QuoW].neg) begin
      pix_next = (st[QuoW].ovf || q > 17'd32767) ? 16'sh7fff : q[15:0];
    end else begin
      pix_next = (st[QuoW].ovf || q > 17'd32768) ? 16'sh8000 : 16'((~q) + 17'd1);
    end
  end

endmodule

// File: design/project_point_pinhole.sv
// ----------------------------------------------------------------------------
// project_point_pinhole
// Rigid pose transform and pinhole projection of 3D points to pixels.
// ----------------------------------------------------------------------------
// Accepts one point per cycle unless the output stalls; each passes three
// stages of transform, three of projection products, sum and range check,
// seventeen one-bit divide stages and an output register. The whole pipeline
// holds while the output beat waits. Configuration writes are taken in every
// cycle and should occur only while the pipeline is empty.
module project_point_pinhole (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppp_pkg::point_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ppp_pkg::pixel_t   out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [47:0]       cfg_data
);
  import ppp_pkg::*;

  logic                     en;
  logic [47:0]              rot [3];
  logic signed [31:0]       trans [3];
  logic                     xf_vld, xf_behind;
  logic signed [CoordW-1:0] coord [3];
  logic                     v_vld, v_behind, u_behind;
  logic signed [15:0]       pu, pv;

  assign en        = out_ready || !out_valid;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0]   <= 48'd16384;
      rot[1]   <= 48'd16384 << 16;
      rot[2]   <= 48'd16384 << 32;
      trans[0] <= '0;
      trans[1] <= '0;
      trans[2] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROT_ROW0: rot[0]   <= cfg_data;
        REG_ROT_ROW1: rot[1]   <= cfg_data;
        REG_ROT_ROW2: rot[2]   <= cfg_data;
        REG_TRANS_X:  trans[0] <= cfg_data[31:0];
        REG_TRANS_Y:  trans[1] <= cfg_data[31:0];
        REG_TRANS_Z:  trans[2] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  ppp_xform u_xform (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .pt      (in_data),
    .rot     (rot),
    .trans   (trans),
    .out_vld (xf_vld),
    .coord   (coord),
    .behind  (xf_behind)
  );

  ppp_proj u_proj_u (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (xf_vld),
    .f         (FX_Q16),
    .c         (CX_Q16),
    .a         (coord[0]),
    .z         (coord[2]),
    .behind_in (xf_behind),
    .out_vld   (out_valid),
    .pix       (pu),
    .behind    (u_behind)
  );

  ppp_proj u_proj_v (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (xf_vld),
    .f         (FY_Q16),
    .c         (CY_Q16),
    .a         (coord[1]),
    .z         (coord[2]),
    .behind_in (xf_behind),
    .out_vld   (v_vld),
    .pix       (pv),
    .behind    (v_behind)
  );

  assign out_data.pixel_u       = pu;
  assign out_data.pixel_v       = pv;
  assign out_data.behind_camera = u_behind && (v_behind || !v_vld || v_vld);

endmodule

// File: bench/tb_project_point_pinhole.sv
// ----------------------------------------------------------------------------
// tb_project_point_pinhole
// Self-checking bench for the pose transform and pinhole projection pipeline.
// ----------------------------------------------------------------------------
// Points are queued by phase, driven in random bursts and predicted in
// fixed point as they are accepted. Results are compared in order. Each phase
// writes a new pose while the pipeline is empty, including identity, random
// rotations and the extreme register codes. The output side stalls at random,
// with one long hold-off that backs up the pipeline.
module tb_project_point_pinhole;
  import ppp_pkg::*;

  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 400000;
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  point_t      in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pixel_t      out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_ROT_ROW0;
  logic [47:0] cfg_data = '0;

  logic [47:0]        pose_row [3];
  logic signed [31:0] pose_trans [3];

  point_t pending_points [$];
  pixel_t pixel_queue [$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  bit     hold_off = 1'b0;
  int     hold_cycles = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  bit     in_taken = 1'b0;

  project_point_pinhole DUT (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #1 clk = ~clk;

  function automatic logic signed [63:0] camera_coord(input int r, input point_t p);
    logic signed [63:0] acc;
    acc = $signed(pose_row[r][15:0]) * 64'(p.point_x)
        + $signed(pose_row[r][31:16]) * 64'(p.point_y)
        + $signed(pose_row[r][47:32]) * 64'(p.point_z)
        + 64'(pose_trans[r]) * 64'sd16384;
    return acc / 64'sd16384;
  endfunction

  function automatic logic signed [15:0] pixel_axis(input logic signed [63:0] f,
      input logic signed [63:0] c, input logic signed [63:0] a,
      input logic signed [63:0] z);
    logic signed [63:0] q;
    q = (f * a + c * z) / (z * 64'sd65536);
    if (q > 64'sd32767) q = 64'sd32767;
    if (q < -64'sd32768) q = -64'sd32768;
    return q[15:0];
  endfunction

  function automatic pixel_t project_pixel(input point_t p);
    logic signed [63:0] cx, cy, cz;
    pixel_t r;
    cx = camera_coord(0, p);
    cy = camera_coord(1, p);
    cz = camera_coord(2, p);
    r = '0;
    if (cz <= 0) begin
      r.behind_camera = 1'b1;
    end else begin
      r.pixel_u = pixel_axis(64'(FX_Q16), 64'(CX_Q16), cx, cz);
      r.pixel_v = pixel_axis(64'(FY_Q16), 64'(CY_Q16), cy, cz);
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_q14();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h4000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 3));
      3: return 32'($urandom);
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.point_x = rand_coord();
    p.point_y = rand_coord();
    p.point_z = ($urandom_range(0, 3) == 0) ? rand_coord()
                                             : 32'($urandom_range(1 << 12, 30 << 16));
    return p;
  endfunction

  function automatic point_t make_point(input logic [31:0] x, input logic [31:0] y,
      input logic [31:0] z);
    point_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    return p;
  endfunction

  function automatic void queue_point(input point_t p);
    pending_points.insert(pending_points.size(), p);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROT_ROW0: pose_row[0] = value;
      REG_ROT_ROW1: pose_row[1] = value;
      REG_ROT_ROW2: pose_row[2] = value;
      REG_TRANS_X:  pose_trans[0] = value[31:0];
      REG_TRANS_Y:  pose_trans[1] = value[31:0];
      REG_TRANS_Z:  pose_trans[2] = value[31:0];
      default: ;
    endcase
  endtask

  task automatic wait_empty();
    while (pending_points.size() != 0 || in_valid || pixel_queue.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_points.size() != 0) begin
        in_data  <= pending_points.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accept and predict at the rising edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      pixel_queue.insert(pixel_queue.size(), project_pixel(in_data));
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_t exp_pixel;
    if (!rst && out_valid && out_ready) begin
      if (pixel_queue.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected beat %p", out_data);
      end else begin
        exp_pixel = pixel_queue.pop_front();
        if (out_data !== exp_pixel) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("mismatch: expected %p, got %p", exp_pixel, out_data);
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      else hold_off <= 1'b0;
    end else begin
      case ((cycle_count / 500) % 3)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  initial begin
    int phase;
    pose_row[0] = 48'd16384;
    pose_row[1] = 48'd16384 << 16;
    pose_row[2] = 48'd16384 << 32;
    pose_trans = '{default: '0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset pose: extremes, zero and negative depth, saturation
    queue_point(make_point(32'h0, 32'h0, 32'h0001_0000));
    queue_point(make_point(32'h0, 32'h0, 32'h0));
    queue_point(make_point(32'h0, 32'h0, 32'hffff_0000));
    queue_point(make_point(32'h0, 32'h0, 32'h1));
    queue_point(make_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h1));
    queue_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h1));
    queue_point(make_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    queue_point(make_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    queue_point(make_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    queue_point(make_point(32'h0001_0000, 32'hffff_0000, 32'h0002_0000));
    queue_point(make_point(32'h0, 32'h0, 32'h7fff_ffff));
    wait_empty();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_ROT_ROW0, 48'hffff_ffff_ffff);
          write_reg(REG_ROT_ROW1, 48'h8000_8000_8000);
          write_reg(REG_ROT_ROW2, 48'h7fff_7fff_7fff);
          write_reg(REG_TRANS_X, 48'h0000_7fff_ffff);
          write_reg(REG_TRANS_Y, 48'hffff_8000_0000);
          write_reg(REG_TRANS_Z, 48'h0000_7fff_ffff);
        end
        1: begin
          write_reg(REG_ROT_ROW0, 48'd16384);
          write_reg(REG_ROT_ROW1, 48'd16384 << 16);
          write_reg(REG_ROT_ROW2, 48'd16384 << 32);
          write_reg(REG_TRANS_X, 48'h0);
          write_reg(REG_TRANS_Y, 48'h0);
          write_reg(REG_TRANS_Z, 48'h0000_8000_0000);
          write_reg(RegSpareLo, 48'h1234_5678_9abc);
          write_reg(RegSpareHi, 48'hffff_ffff_ffff);
        end
        default: begin
          write_reg(REG_ROT_ROW0, {rand_q14(), rand_q14(), rand_q14()});
          write_reg(REG_ROT_ROW1, {rand_q14(), rand_q14(), rand_q14()});
          write_reg(REG_ROT_ROW2, {rand_q14(), rand_q14(), rand_q14()});
          write_reg(REG_TRANS_X, {16'($urandom), rand_coord()});
          write_reg(REG_TRANS_Y, {16'($urandom), rand_coord()});
          write_reg(REG_TRANS_Z, {16'($urandom), rand_coord()});
        end
      endcase
      repeat (phase == 1 ? 30 : 250) queue_point(rand_point());
      if (phase == 3) begin
        hold_cycles = 200;
        hold_off = 1'b1;
      end
      wait_empty();
    end

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
